[rtl/mrwt_pkg.sv]
// Package with the shared default width for the Miller-Rabin witness test unit.
package mrwt_pkg;

  localparam int unsigned DefaultWidth = 32;

endpackage

[rtl/miller_rabin_witness_test_unit.sv]
// Top level of the single-round Miller-Rabin witness test unit.
//
//   Channel  Dir  tdata fields (low bit first)      Beat meaning
//   s_axis   in   candidate, base (WIDTH each)      one test request
//   m_axis   out  composite, trivial_case           one verdict
//
// A trivial candidate (one, two or even) can leave on m_axis the cycle after its beat.
// Other candidates first split off factors of two, then run modular products on the
// shared multiplier, of which there are up to about 2 * WIDTH + 1.
// The block takes no new beat until its verdict has left on m_axis.
// Reset clears the sequencer; data registers are loaded on each beat.
module miller_rabin_witness_test_unit #(
  parameter int unsigned WIDTH = mrwt_pkg::DefaultWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: candidate, base, zero padding.
  input  logic [((2*WIDTH+7)/8)*8-1:0]        s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // Fields from bit 0: composite, trivial_case, zero padding.
  output logic [7:0]                          m_axis_tdata_o
);

  localparam int unsigned TW = $clog2(WIDTH);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSplit = 4'd1;
  localparam logic [3:0] StRed   = 4'd2;
  localparam logic [3:0] StExp   = 4'd3;
  localparam logic [3:0] StMulA  = 4'd4;
  localparam logic [3:0] StMulB  = 4'd5;
  localparam logic [3:0] StSq    = 4'd6;
  localparam logic [3:0] StSqW   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] u_q, u_d;
  logic [TW-1:0]    t_q, t_d;
  logic [TW-1:0]    i_q, i_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic             comp_q, comp_d;
  logic             triv_q, triv_d;

  logic             mul_start;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;

  logic [WIDTH-1:0] in_n;
  logic [WIDTH-1:0] in_a;
  logic [WIDTH-1:0] n_m1;
  logic             accept;

  assign in_n   = s_axis_tdata_i[WIDTH-1:0];
  assign in_a   = s_axis_tdata_i[2*WIDTH-1:WIDTH];
  assign n_m1   = n_q - WIDTH'(1);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    a_d       = a_q;
    u_d       = u_q;
    t_d       = t_q;
    i_d       = i_q;
    acc_d     = acc_q;
    b_d       = b_q;
    x_d       = x_q;
    comp_d    = comp_q;
    triv_d    = triv_q;
    mul_start = 1'b0;
    mul_x     = acc_q;
    mul_y     = b_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          n_d = in_n;
          a_d = in_a;
          u_d = in_n - WIDTH'(1);
          t_d = '0;
          priority if (in_n == WIDTH'(2)) begin
            comp_d  = 1'b0;
            triv_d  = 1'b1;
            state_d = StOut;
          end else if (in_n == WIDTH'(1) || !in_n[0]) begin
            comp_d  = 1'b1;
            triv_d  = 1'b1;
            state_d = StOut;
          end else begin
            triv_d  = 1'b0;
            state_d = StSplit;
          end
        end
      end
      StSplit: begin
        if (!u_q[0]) begin
          u_d = {1'b0, u_q[WIDTH-1:1]};
          t_d = t_q + TW'(1);
        end else begin
          mul_start = 1'b1;
          mul_x     = WIDTH'(1);
          mul_y     = a_q;
          state_d   = StRed;
        end
      end
      StRed: begin
        if (mul_done) begin
          b_d     = mul_res;
          acc_d   = WIDTH'(1);
          state_d = StExp;
        end
      end
      StExp: begin
        priority if (u_q == '0) begin
          x_d     = acc_q;
          i_d     = '0;
          state_d = StSq;
        end else if (u_q[0]) begin
          mul_start = 1'b1;
          state_d   = StMulA;
        end else begin
          mul_start = 1'b1;
          mul_x     = b_q;
          state_d   = StMulB;
        end
      end
      StMulA: begin
        if (mul_done) begin
          acc_d     = mul_res;
          mul_start = 1'b1;
          mul_x     = b_q;
          state_d   = StMulB;
        end
      end
      StMulB: begin
        if (mul_done) begin
          b_d     = mul_res;
          u_d     = {1'b0, u_q[WIDTH-1:1]};
          state_d = StExp;
        end
      end
      StSq: begin
        if (i_q == t_q) begin
          comp_d  = (x_q != WIDTH'(1));
          state_d = StOut;
        end else begin
          mul_start = 1'b1;
          mul_x     = x_q;
          mul_y     = x_q;
          state_d   = StSqW;
        end
      end
      StSqW: begin
        if (mul_done) begin
          if (mul_res == WIDTH'(1) && x_q != WIDTH'(1) && x_q != n_m1) begin
            comp_d  = 1'b1;
            state_d = StOut;
          end else begin
            x_d     = mul_res;
            i_d     = i_q + TW'(1);
            state_d = StSq;
          end
        end
      end
      StOut: begin
        if (m_axis_tready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    a_q    <= a_d;
    u_q    <= u_d;
    t_q    <= t_d;
    i_q    <= i_d;
    acc_q  <= acc_d;
    b_q    <= b_d;
    x_q    <= x_d;
    comp_q <= comp_d;
    triv_q <= triv_d;
  end

  mrwt_modmul #(
    .WIDTH (WIDTH)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .m_i     (n_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {6'b000000, triv_q, comp_q};

endmodule

[rtl/mrwt_modmul.sv]
// Iterative modular multiplier that adds one multiplier bit per cycle, MSB first.
module mrwt_modmul #(
  parameter int unsigned WIDTH = mrwt_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] res_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] m_q, m_d;

  logic [WIDTH+2:0] sum;
  logic [WIDTH+2:0] diff1;
  logic [WIDTH+2:0] diff2;

  always_comb begin
    sum   = {2'b00, acc_q, 1'b0} + {3'b000, (y_q[WIDTH-1] ? x_q : '0)};
    diff1 = sum - {3'b000, m_q};
    diff2 = sum - {2'b00, m_q, 1'b0};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH);
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
      m_d    = m_i;
    end else if (busy_q) begin
      priority if (!diff2[WIDTH+2]) begin
        acc_d = diff2[WIDTH-1:0];
      end else if (!diff1[WIDTH+2]) begin
        acc_d = diff1[WIDTH-1:0];
      end else begin
        acc_d = sum[WIDTH-1:0];
      end
      y_d   = {y_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Miller-Rabin witness test unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = mrwt_pkg::DefaultWidth;
  localparam int unsigned IN_W = ((2 * W + 7) / 8) * 8;
  localparam int NUM_DIRECTED = 24;
  localparam int RANDOM_ITEMS = 116;
  localparam int TOTAL_ITEMS = NUM_DIRECTED + RANDOM_ITEMS;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIGHT_IDLE_PCT = 36;
  localparam int HEAVY_IDLE_PCT = 87;

  typedef struct packed {
    logic trivial_case;
    logic composite;
  } verdict_t;

  localparam verdict_t TRIV_PRIME = '{trivial_case: 1'b1, composite: 1'b0};
  localparam verdict_t TRIV_COMPOSITE = '{trivial_case: 1'b1, composite: 1'b1};
  localparam verdict_t FULL_PRIME = '{trivial_case: 1'b0, composite: 1'b0};
  localparam verdict_t FULL_COMPOSITE = '{trivial_case: 1'b0, composite: 1'b1};

  typedef struct {
    logic [W-1:0] candidate;
    logic [W-1:0] base;
    bit           typed;
    verdict_t     verdict;
  } directed_row_t;

  typedef struct {
    logic [W-1:0] candidate;
    logic [W-1:0] base;
    verdict_t     verdict;
  } verdict_check_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid_i;
  logic            s_axis_tready_o;
  // Fields from bit 0: candidate, base, zero padding.
  logic [IN_W-1:0] s_axis_tdata_i;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i;
  // Fields from bit 0: composite, trivial_case, zero padding.
  logic [7:0]      m_axis_tdata_o;

  verdict_check_t  pending_verdicts[$];
  verdict_check_t  next_check;
  directed_row_t   directed_rows[NUM_DIRECTED];
  int              mismatches = 0;
  int              quiet_cycles = 0;
  int              src_idle_pct = LIGHT_IDLE_PCT;
  int              dst_idle_pct = HEAVY_IDLE_PCT;

  miller_rabin_witness_test_unit #(
    .WIDTH(W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit [63:0] mul_mod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic bit [63:0] pow_mod(bit [63:0] b, bit [63:0] e, bit [63:0] m);
    bit [63:0] acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) begin
        acc = mul_mod(acc, b, m);
      end
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // The candidate is odd and at least three here.
  function automatic logic has_witness(bit [63:0] a, bit [63:0] n);
    bit [63:0] odd_part;
    bit [63:0] prev;
    bit [63:0] cur;
    int        twos;
    odd_part = n - 1;
    twos = 0;
    while (!odd_part[0]) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    prev = pow_mod(a, odd_part, n);
    cur = prev;
    for (int i = 0; i < twos; i++) begin
      cur = mul_mod(prev, prev, n);
      if (cur == 1 && prev != 1 && prev != n - 1) begin
        return 1'b1;
      end
      prev = cur;
    end
    return cur != 1;
  endfunction

  function automatic verdict_t predict_verdict(logic [W-1:0] cand, logic [W-1:0] base);
    verdict_t v;
    if (cand == 2) begin
      v = TRIV_PRIME;
    end else if (cand == 1 || !cand[0]) begin
      v = TRIV_COMPOSITE;
    end else begin
      v.trivial_case = 1'b0;
      v.composite = has_witness(64'(base), 64'(cand));
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    verdict_check_t want;
    verdict_t       got;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[1:0];
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict beat 0x%0h with no request outstanding",
                                  m_axis_tdata_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.composite !== want.verdict.composite) begin
          report_mismatch($sformatf("n=%0d a=%0d composite want %0b got %0b",
                                    want.candidate, want.base,
                                    want.verdict.composite, got.composite));
        end
        if (got.trivial_case !== want.verdict.trivial_case) begin
          report_mismatch($sformatf("n=%0d a=%0d trivial_case want %0b got %0b",
                                    want.candidate, want.base,
                                    want.verdict.trivial_case, got.trivial_case));
        end
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      pending_verdicts.push_back(next_check);
    end
    if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns no beat for %0d cycles", $time, STALL_LIMIT);
      $display("miller_rabin_witness_test_unit regression: fail");
      $finish;
    end
  end

  initial begin : verdict_sink
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic send_request(input int item_no, input logic [W-1:0] cand,
                              input logic [W-1:0] base, input bit typed,
                              input verdict_t typed_verdict);
    logic [IN_W-1:0] word;
    case (item_no * 3 / TOTAL_ITEMS)
      0: begin
        src_idle_pct = LIGHT_IDLE_PCT;
        dst_idle_pct = HEAVY_IDLE_PCT;
      end
      1: begin
        src_idle_pct = HEAVY_IDLE_PCT;
        dst_idle_pct = LIGHT_IDLE_PCT;
      end
      default: begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
    endcase
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    word = '0;
    word[W-1:0] = cand;
    word[2*W-1:W] = base;
    next_check.candidate = cand;
    next_check.base = base;
    next_check.verdict = typed ? typed_verdict : predict_verdict(cand, base);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  initial begin : stimulus
    logic [W-1:0] cand;
    logic [W-1:0] base;
    int unsigned  mult;
    int           pick;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    directed_rows = '{
      '{32'd2,          32'd0,          1'b1, TRIV_PRIME},
      '{32'd2,          32'hFFFFFFFF,   1'b1, TRIV_PRIME},
      '{32'd1,          32'd5,          1'b1, TRIV_COMPOSITE},
      '{32'd0,          32'd0,          1'b1, TRIV_COMPOSITE},
      '{32'd0,          32'hFFFFFFFF,   1'b1, TRIV_COMPOSITE},
      '{32'hFFFFFFFE,   32'hFFFFFFFF,   1'b1, TRIV_COMPOSITE},
      '{32'd4,          32'd3,          1'b1, TRIV_COMPOSITE},
      '{32'd3,          32'd0,          1'b1, FULL_COMPOSITE},
      '{32'd7,          32'd14,         1'b1, FULL_COMPOSITE},
      '{32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, FULL_COMPOSITE},
      '{32'd13,         32'd1,          1'b1, FULL_PRIME},
      '{32'd13,         32'd12,         1'b1, FULL_PRIME},
      '{32'd13,         32'd25,         1'b1, FULL_PRIME},
      '{32'd3,          32'd2,          1'b1, FULL_PRIME},
      '{32'hFFFFFFFB,   32'd2,          1'b0, FULL_PRIME},
      '{32'hFFFFFFFB,   32'hFFFFFFFA,   1'b1, FULL_PRIME},
      '{32'hFFFFFFFF,   32'd2,          1'b0, FULL_PRIME},
      '{32'd561,        32'd2,          1'b0, FULL_PRIME},
      '{32'd2047,       32'd2,          1'b0, FULL_PRIME},
      '{32'd3215031751, 32'd2,          1'b0, FULL_PRIME},
      '{32'd25,         32'd7,          1'b0, FULL_PRIME},
      '{32'd97,         32'd5,          1'b0, FULL_PRIME},
      '{32'd65537,      32'hFFFFFFFF,   1'b0, FULL_PRIME},
      '{32'h80000001,   32'h7FFFFFFF,   1'b0, FULL_PRIME}
    };
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(i, directed_rows[i].candidate, directed_rows[i].base,
                   directed_rows[i].typed, directed_rows[i].verdict);
    end

    // Mostly odd candidates so that the exponentiation runs; some small ones hit primes.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        cand = W'($urandom_range(2));
      end else if (pick < 10) begin
        cand = W'($urandom) & ~W'(1);
      end else if (pick < 30) begin
        cand = W'($urandom_range(255, 3)) | W'(1);
      end else begin
        cand = W'($urandom) | W'(1);
      end
      base = W'($urandom);
      if (pick >= 10) begin
        case ($urandom_range(9))
          0: base = W'(1);
          1: base = cand - W'(1);
          2: begin
            mult = $urandom_range(32'hFFFFFFFF / int'(cand));
            base = W'(64'(cand) * 64'(mult));
          end
          default: base = W'($urandom);
        endcase
      end
      send_request(NUM_DIRECTED + i, cand, base, 1'b0, FULL_PRIME);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("miller_rabin_witness_test_unit regression: pass");
    end else begin
      $display("miller_rabin_witness_test_unit regression: fail");
    end
    $finish;
  end

endmodule
